/* rtl/qrm_pkg.sv */
// Shared types, constants and saturation helper for the quaternion rate mapping block.
`default_nettype none

package qrm_pkg;

	localparam int QuoBits = 32;
	localparam logic [31:0] SatPos = 32'h7FFF_FFFF;
	localparam logic [31:0] SatNeg = 32'h8000_0000;
	localparam logic [65:0] FwdHalf = 66'h1_0000;
	localparam logic [48:0] SatMag = 49'h1_0000_0000;

	localparam logic ActFwd = 1'b0;
	localparam logic ActInv = 1'b1;

	typedef struct packed {
		logic valid;
		logic action;
		logic [3:0][31:0] quat;
		logic [3:0][31:0] vec;
	} item_t;

	typedef struct packed {
		logic valid;
		logic action;
		logic [3:0][3:0][63:0] p;
		logic [3:0][63:0] sq;
	} mul_t;

	typedef struct packed {
		logic valid;
		logic action;
		logic [3:0][65:0] s;
		logic [64:0] n2;
	} sum_t;

	typedef struct packed {
		logic valid;
		logic action;
		logic zero;
		logic [3:0] neg;
		logic [3:0][64:0] mag;
		logic [64:0] n2;
	} prep_t;

	typedef struct packed {
		logic valid;
		logic action;
		logic zero;
		logic [2:0] neg;
		logic [2:0] ovf;
		logic [2:0][64:0] rem;
		logic [2:0][QuoBits-1:0] lq;
		logic [64:0] n2;
		logic [3:0][31:0] fres;
		logic fflag;
	} div_t;

	typedef struct packed {
		logic valid;
		logic action;
		logic [3:0][31:0] res;
		logic flag;
	} fin_t;

	// Apply sign to a magnitude and clamp to 32 bits; bit 32 flags saturation.
	function automatic logic [32:0] sat_fix(input logic [48:0] mag, input logic neg);
		logic [32:0] r;
		if (neg) begin
			if (mag > 49'({17'd0, SatNeg})) r = {1'b1, SatNeg};
			else r = {1'b0, 32'd0 - mag[31:0]};
		end else begin
			if (mag > 49'({17'd0, SatPos})) r = {1'b1, SatPos};
			else r = {1'b0, mag[31:0]};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/qrm_ifs.sv */
// Valid/ready channel interfaces for items and results.
`default_nettype none

interface qrm_item_if;
	logic valid;
	logic ready;
	logic action;
	logic signed [31:0] quat_w;
	logic signed [31:0] quat_x;
	logic signed [31:0] quat_y;
	logic signed [31:0] quat_z;
	logic signed [31:0] vec_0;
	logic signed [31:0] vec_1;
	logic signed [31:0] vec_2;
	logic signed [31:0] vec_3;
	modport source(output valid, action, quat_w, quat_x, quat_y, quat_z,
		vec_0, vec_1, vec_2, vec_3, input ready);
	modport sink(input valid, action, quat_w, quat_x, quat_y, quat_z,
		vec_0, vec_1, vec_2, vec_3, output ready);
endinterface

interface qrm_result_if;
	logic valid;
	logic ready;
	logic signed [31:0] res_0;
	logic signed [31:0] res_1;
	logic signed [31:0] res_2;
	logic signed [31:0] res_3;
	logic error_flag;
	modport source(output valid, res_0, res_1, res_2, res_3, error_flag, input ready);
	modport sink(input valid, res_0, res_1, res_2, res_3, error_flag, output ready);
endinterface

`default_nettype wire

/* rtl/quaternion_rate_mapping.sv */
// Quaternion kinematic rate mapping: forward maps body rates to a quaternion
// rate, inverse maps a quaternion rate back to body rates, all in signed
// Q16.16. The block takes one item per clock in either direction while the
// result side does not stall. Each item passes through one product stage,
// one sum stage, two stages to form magnitudes and seed the divide, 32
// divide steps (one quotient bit each, three lanes sharing the squared norm
// as divisor) and a final rounding stage that is also the output register.
// When the result side stalls, every stage holds together and no item is
// lost or repeated.
`default_nettype none

module quaternion_rate_mapping import qrm_pkg::*; (
	input logic clk,
	input logic arst_n,
	qrm_item_if.sink item,
	qrm_result_if.source result
);

	// Advance the whole pipeline unless a finished item waits at the output.
	logic advance;
	item_t item_d;
	mul_t mul_s1;
	sum_t sum_s2;
	div_t div_s [QuoBits+1];
	fin_t fin_s;

	assign advance = !fin_s.valid || result.ready;
	assign item.ready = advance;

	assign item_d.valid = item.valid;
	assign item_d.action = item.action;
	assign item_d.quat[0] = item.quat_w;
	assign item_d.quat[1] = item.quat_x;
	assign item_d.quat[2] = item.quat_y;
	assign item_d.quat[3] = item.quat_z;
	assign item_d.vec[0] = item.vec_0;
	assign item_d.vec[1] = item.vec_1;
	assign item_d.vec[2] = item.vec_2;
	assign item_d.vec[3] = item.vec_3;

	qrm_mul u_mul (.clk(clk), .arst_n(arst_n), .en(advance), .d(item_d), .q(mul_s1));
	qrm_sum u_sum (.clk(clk), .arst_n(arst_n), .en(advance), .d(mul_s1), .q(sum_s2));
	qrm_prep u_prep (.clk(clk), .arst_n(arst_n), .en(advance), .d(sum_s2), .q(div_s[0]));

	// Chain of divide steps, one quotient bit per stage.
	genvar k;
	generate
		for (k = 0; k < QuoBits; k++) begin : g_div
			qrm_div_step u_step (
				.clk(clk), .arst_n(arst_n), .en(advance),
				.d(div_s[k]), .q(div_s[k+1])
			);
		end
	endgenerate

	qrm_round u_round (.clk(clk), .arst_n(arst_n), .en(advance),
		.d(div_s[QuoBits]), .q(fin_s));

	assign result.valid = fin_s.valid;
	assign result.res_0 = fin_s.res[0];
	assign result.res_1 = fin_s.res[1];
	assign result.res_2 = fin_s.res[2];
	assign result.res_3 = fin_s.res[3];
	assign result.error_flag = fin_s.flag;

`ifndef SYNTH
	// An accepted item enters the product stage on the next edge.
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> mul_s1.valid)
		else $error("accepted item did not enter the pipeline");

	// Inverse results never carry a fourth component.
	a_inv_res3: assert property (@(posedge clk) disable iff (!arst_n)
		fin_s.valid && fin_s.action == ActInv |-> fin_s.res[3] == '0)
		else $error("inverse result has nonzero fourth component");

	// A zero-norm inverse item comes out flagged with zero rates.
	a_zero_norm: assert property (@(posedge clk) disable iff (!arst_n)
		advance && div_s[QuoBits].valid && div_s[QuoBits].action == ActInv &&
		div_s[QuoBits].zero |=> result.valid && result.error_flag &&
		result.res_0 == '0 && result.res_1 == '0 && result.res_2 == '0)
		else $error("zero-norm item not flagged or not zeroed");
`endif

endmodule

`default_nettype wire

/* rtl/qrm_mul.sv */
// Product stage: all quaternion-by-vector products and the four squares.
`default_nettype none

module qrm_mul import qrm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input item_t d,
	output mul_t q
);

	logic signed [63:0] prod [4][4];
	logic signed [63:0] sqr [4];

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int j = 0; j < 4; j++) begin
				prod[c][j] = $signed(d.quat[c]) * $signed(d.vec[j]);
			end
			sqr[c] = $signed(d.quat[c]) * $signed(d.quat[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q.valid <= d.valid;
			q.action <= d.action;
			for (int c = 0; c < 4; c++) begin
				for (int j = 0; j < 4; j++) begin
					q.p[c][j] <= prod[c][j];
				end
				q.sq[c] <= sqr[c];
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/qrm_sum.sv */
// Sum stage: signed row sums for either direction and the squared norm.
`default_nettype none

module qrm_sum import qrm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input mul_t d,
	output sum_t q
);

	logic signed [65:0] pp [4][4];
	logic signed [65:0] sel [4];
	logic [64:0] n2;

	// Component index: w=0, x=1, y=2, z=3.
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int j = 0; j < 4; j++) begin
				pp[c][j] = 66'($signed(d.p[c][j]));
			end
		end
		if (d.action == ActFwd) begin
			sel[0] = -pp[1][0] - pp[2][1] - pp[3][2];
			sel[1] =  pp[0][0] + pp[3][1] - pp[2][2];
			sel[2] = -pp[3][0] + pp[0][1] + pp[1][2];
			sel[3] =  pp[2][0] - pp[1][1] + pp[0][2];
		end else begin
			sel[0] = -pp[1][0] + pp[0][1] - pp[3][2] + pp[2][3];
			sel[1] = -pp[2][0] + pp[3][1] + pp[0][2] - pp[1][3];
			sel[2] = -pp[3][0] - pp[2][1] + pp[1][2] + pp[0][3];
			sel[3] = '0;
		end
		n2 = 65'(d.sq[0]) + 65'(d.sq[1]) + 65'(d.sq[2]) + 65'(d.sq[3]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q.valid <= d.valid;
			q.action <= d.action;
			for (int i = 0; i < 4; i++) begin
				q.s[i] <= sel[i];
			end
			q.n2 <= n2;
		end
	end

endmodule

`default_nettype wire

/* rtl/qrm_prep.sv */
// Two stages: take magnitudes, then finish forward rates and seed the divider.
`default_nettype none

module qrm_prep import qrm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input sum_t d,
	output div_t q
);

	prep_t p_s3;
	logic [3:0] neg;
	logic [3:0][64:0] mag;
	logic [3:0][31:0] fres;
	logic [3:0] fsat;
	logic [65:0] tmp [4];
	logic [32:0] fx [4];
	logic [2:0] ovf;
	logic [2:0][64:0] r0;
	logic [2:0][QuoBits-1:0] lq;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			neg[i] = d.s[i][65];
			mag[i] = neg[i] ? 65'(66'd0 - d.s[i]) : d.s[i][64:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_s3 <= '0;
		end else if (en) begin
			p_s3.valid <= d.valid;
			p_s3.action <= d.action;
			p_s3.zero <= (d.n2 == '0);
			p_s3.neg <= neg;
			p_s3.mag <= mag;
			p_s3.n2 <= d.n2;
		end
	end

	// Forward: halve with round half away from zero, clamp.
	// Inverse: top 50 dividend bits decide overflow, low bits shift in later.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			tmp[i] = 66'(p_s3.mag[i]) + FwdHalf;
			fx[i] = sat_fix(tmp[i][65:17], p_s3.neg[i]);
			fres[i] = fx[i][31:0];
			fsat[i] = fx[i][32];
		end
		for (int l = 0; l < 3; l++) begin
			r0[l] = {15'd0, p_s3.mag[l][64:15]};
			ovf[l] = (r0[l] >= p_s3.n2);
			lq[l] = {p_s3.mag[l][14:0], 17'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q.valid <= p_s3.valid;
			q.action <= p_s3.action;
			q.zero <= p_s3.zero;
			q.neg <= p_s3.neg[2:0];
			q.ovf <= ovf;
			q.rem <= r0;
			q.lq <= lq;
			q.n2 <= p_s3.n2;
			q.fres <= fres;
			q.fflag <= |fsat;
		end
	end

endmodule

`default_nettype wire

/* rtl/qrm_div_step.sv */
// One restoring-division step for three lanes sharing one divisor.
`default_nettype none

module qrm_div_step import qrm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input div_t d,
	output div_t q
);

	logic [65:0] r [3];
	logic [2:0] ge;
	logic [65:0] nr [3];
	div_t nq;

	always_comb begin
		nq = d;
		for (int l = 0; l < 3; l++) begin
			r[l] = {d.rem[l], d.lq[l][QuoBits-1]};
			ge[l] = (r[l] >= {1'b0, d.n2});
			nr[l] = ge[l] ? r[l] - {1'b0, d.n2} : r[l];
			nq.rem[l] = nr[l][64:0];
			nq.lq[l] = {d.lq[l][QuoBits-2:0], ge[l]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q <= nq;
		end
	end

endmodule

`default_nettype wire

/* rtl/qrm_round.sv */
// Final stage: round quotients, clamp, and select the result per direction.
`default_nettype none

module qrm_round import qrm_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input div_t d,
	output fin_t q
);

	logic [2:0] inc;
	logic [32:0] q33 [3];
	logic [48:0] m [3];
	logic [32:0] fx [3];
	logic [3:0][31:0] res;
	logic flag;

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			inc[l] = ({d.rem[l], 1'b0} >= {1'b0, d.n2});
			q33[l] = {1'b0, d.lq[l]} + 33'(inc[l]);
			m[l] = d.ovf[l] ? SatMag : 49'(q33[l]);
			fx[l] = sat_fix(m[l], d.neg[l]);
		end
		if (d.action == ActFwd) begin
			res = d.fres;
			flag = d.fflag;
		end else if (d.zero) begin
			res = '0;
			flag = 1'b1;
		end else begin
			res[0] = fx[0][31:0];
			res[1] = fx[1][31:0];
			res[2] = fx[2][31:0];
			res[3] = '0;
			flag = fx[0][32] | fx[1][32] | fx[2][32];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q.valid <= d.valid;
			q.action <= d.action;
			q.res <= res;
			q.flag <= flag;
		end
	end

endmodule

`default_nettype wire

/* test/qrm_checker.sv */
// Checker: predicts each quaternion rate mapping result and compares it field by field.
module qrm_checker (
	input logic clk,
	input logic arst_n,
	qrm_item_if item,
	qrm_result_if result,
	output int fail_count,
	output int pending
);
	typedef struct packed {
		logic signed [31:0] r0;
		logic signed [31:0] r1;
		logic signed [31:0] r2;
		logic signed [31:0] r3;
		logic flag;
	} rate_t;

	rate_t awaited_rates[$];

	// Clamp a signed wide value to 32 bits; raise the flag on overflow.
	function automatic logic signed [31:0] clamp32(input logic signed [127:0] v,
		inout logic flag);
		if (v > 128'sh7FFF_FFFF) begin
			flag = 1'b1;
			return 32'sh7FFF_FFFF;
		end
		if (v < -128'sh8000_0000) begin
			flag = 1'b1;
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// Forward lane: halve the exact Q32.32 sum, round ties away from zero.
	function automatic logic signed [31:0] halve_round(input logic signed [127:0] s,
		inout logic flag);
		logic [127:0] m;
		logic signed [127:0] q;
		m = s[127] ? -s : s;
		m = (m + 128'h1_0000) >> 17;
		q = s[127] ? -$signed(m) : $signed(m);
		return clamp32(q, flag);
	endfunction

	// Inverse lane: 2*s/n2 in Q16.16, nearest with ties away from zero.
	function automatic logic signed [31:0] norm_divide(input logic signed [127:0] s,
		input logic [127:0] n2, inout logic flag);
		logic [127:0] m, quo, rem;
		logic signed [127:0] q;
		m = s[127] ? -s : s;
		m = m << 17;
		quo = m / n2;
		rem = m % n2;
		if (rem >= n2 - rem) quo = quo + 1;
		q = s[127] ? -$signed(quo) : $signed(quo);
		return clamp32(q, flag);
	endfunction

	function automatic rate_t predict_rates(input logic act,
		input logic signed [31:0] qw, qx, qy, qz, v0, v1, v2, v3);
		rate_t r;
		logic f;
		logic signed [127:0] w, x, y, z, a, b, c, d, n2;
		f = 1'b0;
		w = qw; x = qx; y = qy; z = qz;
		a = v0; b = v1; c = v2; d = v3;
		r = '0;
		if (act == qrm_pkg::ActFwd) begin
			r.r0 = halve_round(-x*a - y*b - z*c, f);
			r.r1 = halve_round(w*a + z*b - y*c, f);
			r.r2 = halve_round(-z*a + w*b + x*c, f);
			r.r3 = halve_round(y*a - x*b + w*c, f);
		end else begin
			n2 = w*w + x*x + y*y + z*z;
			if (n2 == 0) begin
				f = 1'b1;
			end else begin
				r.r0 = norm_divide(-x*a + w*b - z*c + y*d, n2, f);
				r.r1 = norm_divide(-y*a + z*b + w*c - x*d, n2, f);
				r.r2 = norm_divide(-z*a - y*b + x*c + w*d, n2, f);
			end
		end
		r.flag = f;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got, exp);
		$display("mismatch %s: got %h expected %h", what, got, exp);
		fail_count++;
	endtask

	assign pending = awaited_rates.size();

	always @(posedge clk) begin
		rate_t e;
		if (arst_n) begin
			if (item.valid && item.ready)
				awaited_rates.push_back(predict_rates(item.action, item.quat_w,
					item.quat_x, item.quat_y, item.quat_z, item.vec_0, item.vec_1,
					item.vec_2, item.vec_3));
			if (result.valid && result.ready) begin
				if (awaited_rates.size() == 0) begin
					report_mismatch("unexpected item", 0, 0);
				end else begin
					e = awaited_rates.pop_front();
					if (result.res_0 !== e.r0) report_mismatch("res_0", result.res_0, e.r0);
					if (result.res_1 !== e.r1) report_mismatch("res_1", result.res_1, e.r1);
					if (result.res_2 !== e.r2) report_mismatch("res_2", result.res_2, e.r2);
					if (result.res_3 !== e.r3) report_mismatch("res_3", result.res_3, e.r3);
					if (result.error_flag !== e.flag)
						report_mismatch("error_flag", result.error_flag, e.flag);
				end
			end
		end else begin
			fail_count = 0;
		end
	end
endmodule

/* test/tb_top.sv */
// Top of the quaternion rate mapping testbench: clock, reset, stimulus and verdict.
module tb_top;
	import qrm_pkg::*;

	logic clk;
	logic arst_n;
	int fail_count;
	int pending;
	logic hold_off;
	logic stimulus_done;

	qrm_item_if item ();
	qrm_result_if result ();

	quaternion_rate_mapping dut (.clk(clk), .arst_n(arst_n), .item(item), .result(result));

	qrm_checker checker_i (.clk(clk), .arst_n(arst_n), .item(item), .result(result),
		.fail_count(fail_count), .pending(pending));

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Pick a component value: mostly modest, sometimes extreme or raw random.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			3, 4: return $urandom;
			default: return 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
		endcase
	endfunction

	// Offer one item after a random gap unless no_gap is set; hold it until taken.
	task automatic send_item(input logic act, input logic [31:0] qw, qx, qy, qz,
		v0, v1, v2, v3, input bit no_gap);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			item.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.valid <= 1'b1;
		item.action <= act;
		item.quat_w <= qw; item.quat_x <= qx; item.quat_y <= qy; item.quat_z <= qz;
		item.vec_0 <= v0; item.vec_1 <= v1; item.vec_2 <= v2; item.vec_3 <= v3;
		@(posedge clk);
		while (!item.ready) @(posedge clk);
	endtask

	task automatic send_random(input logic act, input bit no_gap);
		send_item(act, pick_value(), pick_value(), pick_value(), pick_value(),
			pick_value(), pick_value(), pick_value(), pick_value(), no_gap);
	endtask

	// Stimulus: directed corners first, then random items with a stall burst.
	initial begin
		int k;
		hold_off = 1'b0;
		item.valid = 1'b0;
		item.action = ActFwd;
		{item.quat_w, item.quat_x, item.quat_y, item.quat_z} = '0;
		{item.vec_0, item.vec_1, item.vec_2, item.vec_3} = '0;
		stimulus_done = 1'b0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// identity quaternion, whole-number rates in both directions
		send_item(ActFwd, 32'h1_0000, 0, 0, 0, 32'h1_0000, 32'h2_0000, 32'h3_0000, 5, 0);
		send_item(ActInv, 32'h1_0000, 0, 0, 0, 0, 32'h1_0000, 32'h2_0000, 32'h3_0000, 0);
		// zero quaternion: inverse flags, forward does not
		send_item(ActInv, 0, 0, 0, 0, 32'h1_0000, 32'h1_0000, 1, 1, 0);
		send_item(ActFwd, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1, 1, 0);
		// saturation with all extremes
		send_item(ActFwd, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
		send_item(ActFwd, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		send_item(ActInv, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		// tiny norms, one of which divides to overflow
		send_item(ActInv, 1, 0, 0, 0, 32'h1_0000, 32'h1_0000, 0, 0, 0);
		send_item(ActInv, 0, 0, 0, 1, 32'hFFFF_FFFF, 0, 0, 0, 0);
		// rounding of small results in both directions
		send_item(ActFwd, 0, 32'hFFFF_FFFF, 0, 0, 32'h0_8000, 0, 0, 0, 0);
		send_item(ActFwd, 32'h0_0001, 32'h0_0001, 32'h0_0001, 32'h0_0001, 1, 1, 1, 1, 0);
		send_item(ActInv, 32'h3_0000, 0, 0, 0, 0, 32'h1, 32'hFFFF_FFFF, 32'h2, 0);
		for (k = 0; k < 8; k++) send_random(k[0], 0);
		// random part; a long receiver hold-off runs in the middle
		for (k = 0; k < 750; k++) begin
			if (k == 300) hold_off <= 1'b1;
			send_random($urandom_range(0, 1), (k >= 300 && k < 360) || k % 97 < 10);
		end
		item.valid <= 1'b0;
		stimulus_done <= 1'b1;
	end

	// Receiver: random stalls, plus one long hold-off counted in cycles.
	initial begin
		int wait_cycles;
		bit hold_done;
		hold_done = 1'b0;
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_off && !hold_done) begin
				result.ready <= 1'b0;
				repeat (200) @(posedge clk);
				hold_done = 1'b1;
			end
			wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
			if (wait_cycles == 0) begin
				result.ready <= 1'b1;
			end else begin
				result.ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
				result.ready <= 1'b1;
			end
			@(posedge clk);
		end
	end

	// Wait for drain plus the pipeline depth, then give the verdict.
	initial begin
		@(posedge clk);
		wait (stimulus_done);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	// Timeout guard
	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule

/* sim.f */
rtl/qrm_pkg.sv
rtl/qrm_ifs.sv
rtl/qrm_mul.sv
rtl/qrm_sum.sv
rtl/qrm_prep.sv
rtl/qrm_div_step.sv
rtl/qrm_round.sv
rtl/quaternion_rate_mapping.sv
test/qrm_checker.sv
test/tb_top.sv
